// ===== src/rfrp_pkg.sv =====
// Package for the RFID reader frame parser: types, codes and constants.
`default_nettype none
package rfrp_pkg;

    localparam int MAX_BUFFER_DEF = 1024;
    localparam int LEN_W          = 11;
    localparam int CFG_DATA_W     = 16;

    localparam logic [7:0] HEAD_BYTE   = 8'hA0;
    localparam logic [7:0] TAG_TYPE    = 8'h13;
    localparam logic [7:0] NODATA_TYPE = 8'h0A;
    localparam logic [7:0] SIG_BYTE2   = 8'h01;
    localparam logic [7:0] SIG_BYTE3   = 8'h8B;

    localparam logic [4:0] TAG_FRAME_LAST    = 5'd20;
    localparam logic [4:0] NODATA_FRAME_LAST = 5'd11;
    localparam logic [4:0] FRAME_BODY_START  = 5'd2;
    localparam logic [LEN_W-1:0] MIN_BUFFER  = 11'd12;
    localparam logic [LEN_W-1:0] POS_MAX     = 11'h7FF;

    localparam logic [15:0] READ_INTERVAL_RST    = 16'd10;
    localparam logic [7:0]  UNANSWERED_LIMIT_RST = 8'd20;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        REG_READ_INTERVAL    = 1'b0,
        REG_UNANSWERED_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_TAG  = 2'd0,
        KIND_READ = 2'd1,
        KIND_DISC = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_TAG  = 4'b0100,
        PH_SKIP = 4'b1000
    } t_phase;

    typedef struct packed {
        t_kind       result_kind;
        logic [15:0] reader_id;
        logic [15:0] input_number;
        logic [31:0] tag_number;
        logic [7:0]  frame_checksum;
        logic        last_of_run;
    } t_result;

    // Up to two results handed from the parser to the output queue at once.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage
`default_nettype wire

// ===== src/rfrp_if.sv =====
// Channel interfaces: request input, result output and register write.
`default_nettype none
interface rfrp_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic                          link_up;
    logic [7:0]                    rx_byte;
    logic                          start_of_buffer;
    logic [rfrp_pkg::LEN_W-1:0]    buffer_length;

    modport source (output valid, command, link_up, rx_byte, start_of_buffer,
                    buffer_length, input ready);
    modport sink   (input valid, command, link_up, rx_byte, start_of_buffer,
                    buffer_length, output ready);
endinterface

interface rfrp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] reader_id;
    logic [15:0] input_number;
    logic [31:0] tag_number;
    logic [7:0]  frame_checksum;
    logic        last_of_run;

    modport source (output valid, result_kind, reader_id, input_number, tag_number,
                    frame_checksum, last_of_run, input ready);
    modport sink   (input valid, result_kind, reader_id, input_number, tag_number,
                    frame_checksum, last_of_run, output ready);
endinterface

interface rfrp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic                               index;
    logic [rfrp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/rfrp_core.sv =====
// Input register, frame parser, poll scheduler and configuration registers.
`default_nettype none
module rfrp_core #(
    parameter int MAX_BUFFER = rfrp_pkg::MAX_BUFFER_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    rfrp_req_if.sink            i_req,
    rfrp_cfg_if.sink            i_cfg,
    input  wire logic           i_space_ok,
    output rfrp_pkg::t_push     o_push
);

    localparam logic [rfrp_pkg::LEN_W-1:0] MAX_CLAMP =
        (MAX_BUFFER > 2047) ? rfrp_pkg::POS_MAX : rfrp_pkg::LEN_W'(MAX_BUFFER);

    // input register
    logic                          r_vld;
    logic                          r_cmd;
    logic                          r_link;
    logic [7:0]                    r_byte;
    logic                          r_start;
    logic [rfrp_pkg::LEN_W-1:0]    r_len;

    // configuration
    logic [15:0] r_interval;
    logic [7:0]  r_limit;

    // parser and scheduler state
    rfrp_pkg::t_phase              r_phase, n_phase;
    logic [4:0]                    r_off, n_off;
    logic [rfrp_pkg::LEN_W-1:0]    r_pos, n_pos;
    logic                          r_acc, n_acc;
    logic [15:0]                   r_rid, n_rid;
    logic [15:0]                   r_inp, n_inp;
    logic [31:0]                   r_tag, n_tag;
    logic [15:0]                   r_tick, n_tick;
    logic [7:0]                    r_unans, n_unans;
    logic                          r_ans, n_ans;

    logic proc;
    logic accept;

    // tick path terms
    logic [15:0] tc1;
    logic        fire;
    logic [7:0]  uc1;
    logic        disc;

    // byte path terms
    logic [rfrp_pkg::LEN_W-1:0] pos;
    logic [rfrp_pkg::LEN_W-1:0] eff;
    logic                       acc_a;
    logic                       acc_b;
    rfrp_pkg::t_phase           ph_a;
    logic [4:0]                 off_a;

    rfrp_pkg::t_result res_read;
    rfrp_pkg::t_result res_disc;
    rfrp_pkg::t_result res_tag;

    assign proc        = r_vld && i_space_ok;
    assign i_req.ready = !r_vld || i_space_ok;
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (proc) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_req.command;
            r_link  <= i_req.link_up;
            r_byte  <= i_req.rx_byte;
            r_start <= i_req.start_of_buffer;
            r_len   <= i_req.buffer_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= rfrp_pkg::READ_INTERVAL_RST;
            r_limit    <= rfrp_pkg::UNANSWERED_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (rfrp_pkg::t_reg_idx'(i_cfg.index))
                rfrp_pkg::REG_READ_INTERVAL:    r_interval <= i_cfg.data;
                rfrp_pkg::REG_UNANSWERED_LIMIT: r_limit    <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rfrp_pkg::PH_HUNT;
            r_off   <= '0;
            r_pos   <= '0;
            r_acc   <= 1'b0;
            r_rid   <= '0;
            r_inp   <= '0;
            r_tag   <= '0;
            r_tick  <= 16'hFFFF;
            r_unans <= '0;
            r_ans   <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_rid   <= n_rid;
            r_inp   <= n_inp;
            r_tag   <= n_tag;
            r_tick  <= n_tick;
            r_unans <= n_unans;
            r_ans   <= n_ans;
        end
    end

    // Poll tick: saturating tick count, then unanswered-read bookkeeping.
    assign tc1  = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;
    assign fire = (tc1 >= r_interval);
    assign uc1  = !fire ? r_unans :
                  r_ans ? 8'd0 :
                  (r_unans != 8'hFF) ? r_unans + 8'd1 : r_unans;
    assign disc = (uc1 >= r_limit);

    // Received byte: position within buffer and buffer acceptance.
    assign pos   = r_start ? '0 : r_pos;
    assign eff   = (r_len > MAX_CLAMP) ? MAX_CLAMP : r_len;
    assign acc_a = r_start ? ((eff >= rfrp_pkg::MIN_BUFFER) && (r_byte == rfrp_pkg::HEAD_BYTE))
                           : r_acc;
    assign acc_b = acc_a && (eff >= rfrp_pkg::MIN_BUFFER)
                 && !((pos == 11'd2) && (r_byte != rfrp_pkg::SIG_BYTE2))
                 && !((pos == 11'd3) && (r_byte != rfrp_pkg::SIG_BYTE3));
    assign ph_a  = r_start ? rfrp_pkg::PH_HUNT : r_phase;
    assign off_a = r_start ? 5'd0 : r_off;

    always_comb begin
        res_read             = '0;
        res_read.result_kind = rfrp_pkg::KIND_READ;
        res_read.last_of_run = !disc;
        res_disc             = '0;
        res_disc.result_kind = rfrp_pkg::KIND_DISC;
        res_disc.last_of_run = 1'b1;
        res_tag.result_kind    = rfrp_pkg::KIND_TAG;
        res_tag.reader_id      = r_rid;
        res_tag.input_number   = r_inp;
        res_tag.tag_number     = r_tag;
        res_tag.frame_checksum = r_byte;
        res_tag.last_of_run    = 1'b1;
    end

    always_comb begin
        n_phase = r_phase;
        n_off   = r_off;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_rid   = r_rid;
        n_inp   = r_inp;
        n_tag   = r_tag;
        n_tick  = r_tick;
        n_unans = r_unans;
        n_ans   = r_ans;
        o_push  = '0;
        if (proc) begin
            if (rfrp_pkg::t_cmd'(r_cmd) == rfrp_pkg::CMD_TICK) begin
                if (r_link) begin
                    n_tick  = fire ? 16'd0 : tc1;
                    n_unans = disc ? 8'd0 : uc1;
                    if (fire) begin
                        n_ans = 1'b0;
                    end
                    priority if (fire && disc) begin
                        o_push.count = 2'd2;
                        o_push.r0    = res_read;
                        o_push.r1    = res_disc;
                    end else if (fire) begin
                        o_push.count = 2'd1;
                        o_push.r0    = res_read;
                    end else if (disc) begin
                        o_push.count = 2'd1;
                        o_push.r0    = res_disc;
                    end else begin
                        o_push.count = 2'd0;
                    end
                end
            end else begin
                n_pos   = (pos != rfrp_pkg::POS_MAX) ? pos + 11'd1 : pos;
                n_phase = ph_a;
                n_off   = off_a;
                n_acc   = acc_a;
                // drop bytes past the buffer end
                if (pos < eff) begin
                    n_acc = acc_b;
                    if ((pos == 11'd3) && (r_byte == rfrp_pkg::SIG_BYTE3) && acc_b) begin
                        n_ans = 1'b1;
                    end
                    unique case (ph_a)
                        rfrp_pkg::PH_HUNT: begin
                            if (r_byte == rfrp_pkg::HEAD_BYTE) begin
                                n_phase = rfrp_pkg::PH_HEAD;
                            end
                        end
                        rfrp_pkg::PH_HEAD: begin
                            priority if (r_byte == rfrp_pkg::TAG_TYPE) begin
                                n_phase = rfrp_pkg::PH_TAG;
                                n_off   = rfrp_pkg::FRAME_BODY_START;
                            end else if (r_byte == rfrp_pkg::NODATA_TYPE) begin
                                n_phase = rfrp_pkg::PH_SKIP;
                                n_off   = rfrp_pkg::FRAME_BODY_START;
                            end else if (r_byte != rfrp_pkg::HEAD_BYTE) begin
                                n_phase = rfrp_pkg::PH_HUNT;
                            end else begin
                                n_phase = rfrp_pkg::PH_HEAD;
                            end
                        end
                        rfrp_pkg::PH_TAG: begin
                            if ((off_a == 5'd2) || (off_a == 5'd3)) begin
                                n_rid = {r_rid[7:0], r_byte};
                            end else if ((off_a == 5'd4) || (off_a == 5'd5)) begin
                                n_inp = {r_inp[7:0], r_byte};
                            end else if ((off_a >= 5'd15) && (off_a <= 5'd18)) begin
                                n_tag = {r_tag[23:0], r_byte};
                            end
                            if (off_a >= rfrp_pkg::TAG_FRAME_LAST) begin
                                if (acc_b) begin
                                    o_push.count = 2'd1;
                                    o_push.r0    = res_tag;
                                end
                                n_phase = rfrp_pkg::PH_HUNT;
                                n_off   = '0;
                            end else begin
                                n_off = off_a + 5'd1;
                            end
                        end
                        rfrp_pkg::PH_SKIP: begin
                            if (off_a >= rfrp_pkg::NODATA_FRAME_LAST) begin
                                n_phase = rfrp_pkg::PH_HUNT;
                                n_off   = '0;
                            end else begin
                                n_off = off_a + 5'd1;
                            end
                        end
                        default: begin
                            n_phase = rfrp_pkg::PH_HUNT;
                        end
                    endcase
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/rfrp_out_fifo.sv =====
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module rfrp_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  rfrp_pkg::t_push     i_push,
    output logic                o_space_ok,
    rfrp_res_if.source          o_res
);

    rfrp_pkg::t_result r_mem [4];
    logic [1:0]        r_wr, r_rd;
    logic [2:0]        r_cnt;
    logic              pop;
    logic [1:0]        wr1;

    assign pop        = o_res.valid && o_res.ready;
    assign o_space_ok = (r_cnt <= 3'd2);
    assign wr1        = r_wr + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push.count;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push.count} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

    assign o_res.valid          = (r_cnt != 3'd0);
    assign o_res.result_kind    = r_mem[r_rd].result_kind;
    assign o_res.reader_id      = r_mem[r_rd].reader_id;
    assign o_res.input_number   = r_mem[r_rd].input_number;
    assign o_res.tag_number     = r_mem[r_rd].tag_number;
    assign o_res.frame_checksum = r_mem[r_rd].frame_checksum;
    assign o_res.last_of_run    = r_mem[r_rd].last_of_run;

endmodule
`default_nettype wire

// ===== src/rfrp_reader_frame_parser_top.sv =====
// Top level of the RFID reader frame parser and poll scheduler.
//
//  channel   dir  handshake       payload
//  i_req     in   valid / ready   command, link_up, rx_byte, start_of_buffer, buffer_length
//  o_res     out  valid / ready   result_kind, reader_id, input_number, tag_number,
//                                 frame_checksum, last_of_run
//  i_cfg     in   valid / ready   index (0 read_interval, 1 unanswered_limit), data
//
// One request per cycle while the queue has room: it is registered, then parsed, and its
// results (at most one for a byte, up to two for a poll tick) land in a four-entry queue.
// The parser stage holds while the queue has fewer than two free entries.
// Synchronous active-low reset; configuration writes are always ready.
`default_nettype none
module rfid_reader_frame_parser_top #(
    parameter int MAX_BUFFER = rfrp_pkg::MAX_BUFFER_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rfrp_req_if.sink    i_req,
    rfrp_res_if.source  o_res,
    rfrp_cfg_if.sink    i_cfg
);

    rfrp_pkg::t_push push;
    logic            space_ok;

    rfrp_core #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (i_cfg),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    rfrp_out_fifo u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire

// ===== tb/sv/rfid_reader_frame_parser_top_tb.sv =====
// Testbench for the RFID reader frame parser: directed table, then predicted random traffic.
`timescale 1ns / 100ps
module rfid_reader_frame_parser_top_tb;
    import rfrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int FLOOD_BYTES    = 1050;
    localparam int PHASE_ITEMS    = 90;
    localparam logic [LEN_W-1:0] BUF_CAP = LEN_W'(MAX_BUFFER_DEF);

    typedef struct packed {
        t_cmd             cmd;
        logic             link;
        logic [7:0]       data;
        logic             sob;
        logic [LEN_W-1:0] len;
    } rq_t;

    // n_lit < 0: take the results from the predictor, 0: no result, above 0: the one typed-in result
    typedef struct {
        rq_t     req;
        int      n_lit;
        t_result lit;
    } dir_row_t;

    localparam t_result NO_RESULT = '0;
    localparam t_result READ_LAST = '{KIND_READ, 16'h0, 16'h0, 32'h0, 8'h0, 1'b1};
    localparam t_result TAG_ONES  = '{KIND_TAG, {SIG_BYTE2, SIG_BYTE3}, 16'hFFFF,
                                      32'hFFFF_FFFF, 8'hFF, 1'b1};

    dir_row_t directed_rows [26] = '{
        '{'{CMD_TICK, 1'b0, 8'h00, 1'b0, 11'd0}, 0, NO_RESULT},
        '{'{CMD_TICK, 1'b1, 8'hFF, 1'b1, 11'h7FF}, 1, READ_LAST},
        '{'{CMD_BYTE, 1'b1, HEAD_BYTE, 1'b0, 11'd12}, 0, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, HEAD_BYTE, 1'b1, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, TAG_TYPE, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, SIG_BYTE2, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b0, SIG_BYTE3, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'h00, 1'b0, 11'd21}, -1, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, 8'hFF, 1'b0, 11'd21}, 1, TAG_ONES},
        '{'{CMD_BYTE, 1'b1, TAG_TYPE, 1'b0, 11'd21}, 0, NO_RESULT},
        '{'{CMD_BYTE, 1'b1, HEAD_BYTE, 1'b1, 11'h7FF}, -1, NO_RESULT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfrp_req_if req_bus ();
    rfrp_res_if res_bus ();
    rfrp_cfg_if cfg_bus ();

    rfid_reader_frame_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the parser and poll scheduler, at reset values
    logic [15:0]      poll_interval    = READ_INTERVAL_RST;
    logic [7:0]       miss_limit       = UNANSWERED_LIMIT_RST;
    t_phase           parse_phase      = PH_HUNT;
    logic [4:0]       parse_offset     = '0;
    logic [LEN_W-1:0] buf_pos          = '0;
    logic             buf_ok           = 1'b0;
    logic [15:0]      rid_acc          = '0;
    logic [15:0]      inp_acc          = '0;
    logic [31:0]      tag_acc          = '0;
    logic [15:0]      ticks_since_read = 16'hFFFF;
    logic [7:0]       misses           = '0;
    logic             reply_seen       = 1'b1;

    t_result    reader_events [$];
    logic [7:0] buf_bytes [$];
    int         mismatch_count = 0;
    int         items_sent     = 0;
    int         tx_idle_pct    = 0;
    int         rx_stall_pct   = 0;
    bit         hold_req       = 1'b0;
    int         quiet_cycles   = 0;

    function automatic int step_reader(input rq_t r, output t_result res [2]);
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] eff;
        int n;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (r.cmd == CMD_TICK) begin
            if (!r.link)
                return 0;
            if (ticks_since_read != 16'hFFFF)
                ticks_since_read++;
            if (ticks_since_read >= poll_interval) begin
                if (!reply_seen) begin
                    if (misses != 8'hFF)
                        misses++;
                end else begin
                    misses = '0;
                end
                ticks_since_read = '0;
                reply_seen = 1'b0;
                res[n].result_kind = KIND_READ;
                n++;
            end
            if (misses >= miss_limit) begin
                misses = '0;
                res[n].result_kind = KIND_DISC;
                n++;
            end
            if (n > 0)
                res[n - 1].last_of_run = 1'b1;
            return n;
        end

        pos = r.sob ? '0 : buf_pos;
        eff = (r.len > BUF_CAP) ? BUF_CAP : r.len;
        buf_pos = (pos != POS_MAX) ? pos + 1'b1 : POS_MAX;
        if (r.sob) begin
            parse_phase = PH_HUNT;
            parse_offset = '0;
            buf_ok = (eff >= MIN_BUFFER) && (r.data == HEAD_BYTE);
        end
        if (pos >= eff)
            return 0;
        if (eff < MIN_BUFFER)
            buf_ok = 1'b0;
        if (pos == 2 && r.data != SIG_BYTE2)
            buf_ok = 1'b0;
        if (pos == 3) begin
            if (r.data != SIG_BYTE3)
                buf_ok = 1'b0;
            else if (buf_ok)
                reply_seen = 1'b1;
        end

        case (parse_phase)
            PH_HUNT: begin
                if (r.data == HEAD_BYTE)
                    parse_phase = PH_HEAD;
            end
            PH_HEAD: begin
                if (r.data == TAG_TYPE) begin
                    parse_phase = PH_TAG;
                    parse_offset = FRAME_BODY_START;
                end else if (r.data == NODATA_TYPE) begin
                    parse_phase = PH_SKIP;
                    parse_offset = FRAME_BODY_START;
                end else if (r.data != HEAD_BYTE) begin
                    parse_phase = PH_HUNT;
                end
            end
            PH_TAG: begin
                // reader id at 2..3, input at 4..5, tag id at 15..18
                if (parse_offset == 5'd2 || parse_offset == 5'd3)
                    rid_acc = {rid_acc[7:0], r.data};
                else if (parse_offset == 5'd4 || parse_offset == 5'd5)
                    inp_acc = {inp_acc[7:0], r.data};
                else if (parse_offset >= 5'd15 && parse_offset <= 5'd18)
                    tag_acc = {tag_acc[23:0], r.data};
                if (parse_offset >= TAG_FRAME_LAST) begin
                    if (buf_ok) begin
                        res[0] = '{KIND_TAG, rid_acc, inp_acc, tag_acc, r.data, 1'b1};
                        n = 1;
                    end
                    parse_phase = PH_HUNT;
                    parse_offset = '0;
                end else begin
                    parse_offset++;
                end
            end
            default: begin
                if (parse_offset >= NODATA_FRAME_LAST) begin
                    parse_phase = PH_HUNT;
                    parse_offset = '0;
                end else begin
                    parse_offset++;
                end
            end
        endcase
        return n;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (reader_events.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing outstanding, expected none, got kind %0d",
                         $time, res_bus.result_kind);
            end else begin
                want = reader_events.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(res_bus.result_kind));
                check_field("reader_id", 32'(want.reader_id), 32'(res_bus.reader_id));
                check_field("input_number", 32'(want.input_number),
                            32'(res_bus.input_number));
                check_field("tag_number", want.tag_number, res_bus.tag_number);
                check_field("frame_checksum", 32'(want.frame_checksum),
                            32'(res_bus.frame_checksum));
                check_field("last_of_run", 32'(want.last_of_run), 32'(res_bus.last_of_run));
            end
        end
    end

    // Bail out when no channel moves anything for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        int held;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    res_bus.ready <= 1'b0;
                    @(posedge i_clk);
                    held++;
                end
            end
            res_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic offer(input rq_t r, input int n_lit = -1, input t_result lit = NO_RESULT);
        t_result res [2];
        int n;
        if ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_bus.valid           <= 1'b1;
        req_bus.command         <= r.cmd;
        req_bus.link_up         <= r.link;
        req_bus.rx_byte         <= r.data;
        req_bus.start_of_buffer <= r.sob;
        req_bus.buffer_length   <= r.len;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        n = step_reader(r, res);
        if (n_lit < 0) begin
            for (int k = 0; k < n; k++)
                reader_events.push_back(res[k]);
        end else if (n_lit > 0) begin
            reader_events.push_back(lit);
        end
        items_sent++;
    endtask

    task automatic drain_reports(input int extra);
        req_bus.valid <= 1'b0;
        while (reader_events.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        if (idx == REG_READ_INTERVAL)
            poll_interval = val;
        else
            miss_limit = val[7:0];
    endtask

    task automatic send_tick();
        rq_t r;
        r.cmd  = CMD_TICK;
        r.link = ($urandom_range(9) != 0);
        r.data = 8'($urandom);
        r.sob  = 1'($urandom);
        r.len  = LEN_W'($urandom);
        offer(r);
    endtask

    // Append one tag or no-data frame; the first frame of a buffer carries the signature
    task automatic append_frame(input bit is_tag, input bit first);
        int base;
        int last;
        base = buf_bytes.size();
        last = is_tag ? int'(TAG_FRAME_LAST) : int'(NODATA_FRAME_LAST);
        buf_bytes.push_back(HEAD_BYTE);
        buf_bytes.push_back(is_tag ? TAG_TYPE : NODATA_TYPE);
        for (int k = 2; k <= last; k++)
            buf_bytes.push_back(8'($urandom));
        if (first) begin
            buf_bytes[base + 2] = SIG_BYTE2;
            buf_bytes[base + 3] = SIG_BYTE3;
        end
    endtask

    task automatic send_buffer();
        int declared;
        int cut;
        int idx;
        logic [7:0] b;
        rq_t r;
        buf_bytes.delete();
        if ($urandom_range(99) < 10) begin
            // noise buffer
            repeat ($urandom_range(1, 30))
                buf_bytes.push_back(8'($urandom));
            if ($urandom_range(1))
                buf_bytes[0] = HEAD_BYTE;
            declared = $urandom_range(0, 40);
        end else begin
            for (int f = 0; f < $urandom_range(1, 3); f++) begin
                if (f > 0 && $urandom_range(99) < 30) begin
                    case ($urandom_range(2))
                        0: begin
                            b = 8'($urandom);
                            buf_bytes.push_back(b == HEAD_BYTE ? 8'h00 : b);
                        end
                        1: begin
                            // head byte with a bad type after it
                            b = 8'($urandom);
                            if (b == HEAD_BYTE || b == TAG_TYPE || b == NODATA_TYPE)
                                b = 8'h77;
                            buf_bytes.push_back(HEAD_BYTE);
                            buf_bytes.push_back(b);
                        end
                        default: buf_bytes.push_back(HEAD_BYTE);
                    endcase
                end
                append_frame($urandom_range(99) < 60, f == 0);
            end
            if ($urandom_range(99) < 10) begin
                idx = $urandom_range(2);
                if (idx != 0)
                    idx++;
                buf_bytes[idx] = buf_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            declared = buf_bytes.size();
            cut = $urandom_range(99);
            if (cut < 10) begin
                cut = $urandom_range(1, 10);
                declared = (declared > cut) ? declared - cut : 0;
            end else if (cut < 20) begin
                declared = declared + $urandom_range(1, 8);
            end else if (cut < 25) begin
                declared = $urandom_range(1025, 2047);
            end
        end
        for (int i = 0; i < buf_bytes.size(); i++) begin
            if ($urandom_range(99) < 12)
                send_tick();
            r.cmd  = CMD_BYTE;
            r.link = 1'($urandom);
            r.data = buf_bytes[i];
            r.sob  = (i == 0);
            r.len  = ($urandom_range(99) < 3) ? LEN_W'($urandom_range(0, 11)) : LEN_W'(declared);
            offer(r);
        end
    endtask

    // Long buffer that runs past its clamped length: frames beyond the end are dropped
    task automatic send_flood();
        rq_t r;
        buf_bytes.delete();
        while (buf_bytes.size() < FLOOD_BYTES)
            append_frame(1'b1, buf_bytes.size() == 0);
        for (int i = 0; i < buf_bytes.size(); i++) begin
            r = '{CMD_BYTE, 1'b1, buf_bytes[i], i == 0, POS_MAX};
            offer(r);
        end
    endtask

    task automatic run_phase(input logic [15:0] interval, input logic [15:0] limit,
                             input int tx_pct, input int rx_pct, input bit squeeze);
        int stop_at;
        int halfway;
        bit paused;
        drain_reports(4);
        write_reg(REG_READ_INTERVAL, interval);
        write_reg(REG_UNANSWERED_LIMIT, limit);
        cfg_bus.valid <= 1'b0;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        // hold the result side while requests keep coming, so the block backs up
        if (squeeze)
            hold_req = 1'b1;
        stop_at = items_sent + PHASE_ITEMS;
        halfway = items_sent + PHASE_ITEMS / 2;
        paused  = 1'b0;
        while (items_sent < stop_at) begin
            if (!paused && items_sent >= halfway) begin
                drain_reports(0);
                paused = 1'b1;
            end
            if ($urandom_range(99) < 20)
                send_tick();
            else
                send_buffer();
        end
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        req_bus.valid           <= 1'b0;
        req_bus.command         <= CMD_BYTE;
        req_bus.link_up         <= 1'b0;
        req_bus.rx_byte         <= '0;
        req_bus.start_of_buffer <= 1'b0;
        req_bus.buffer_length   <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= REG_READ_INTERVAL;
        cfg_bus.data            <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].n_lit, directed_rows[i].lit);

        run_phase(16'd1, 16'd255, 0, 0, 1'b1);
        send_flood();
        run_phase(16'd3, 16'd2, 52, 0, 1'b0);
        run_phase(16'd0, 16'd0, 0, 52, 1'b0);
        run_phase(16'hFFFF, 16'd1, 7, 7, 1'b0);
        // upper data bits of the limit register are dropped
        run_phase(16'd2, 16'hA503, 0, 0, 1'b0);

        drain_reports(8);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
src/rfrp_pkg.sv
src/rfrp_if.sv
src/rfrp_core.sv
src/rfrp_out_fifo.sv
src/rfrp_reader_frame_parser_top.sv
tb/sv/rfid_reader_frame_parser_top_tb.sv
